>>> src/bm6_pkg.sv
// Shared types, constants and the character mapping for the bitmap row to printer character block.
package bm6_pkg;

  // Largest row width in pixels that the block honours.
  localparam int MAX_ROW_PIXELS = 8192;

  // Width of the row width register, fixed by the configuration word.
  localparam int CFG_W  = 14;
  // Width of a pixel position within a row.
  localparam int POS_W  = $clog2(MAX_ROW_PIXELS);
  // Width that holds both the register value and the clamp limit.
  localparam int LIM_W  = $clog2(MAX_ROW_PIXELS + 1);
  localparam int EXT_W  = (LIM_W > CFG_W) ? LIM_W : CFG_W;

  localparam int BYTE_W  = 8;
  localparam int CHAR_W  = 7;
  localparam int UNIT_W  = 6;
  localparam int CARRY_W = 4;
  localparam int CCNT_W  = 3;
  localparam int ACC_W   = 12;
  localparam int NCNT_W  = 4;

  // At most four characters come out of one pixel byte.
  localparam int ENT_CHARS = 4;
  localparam int SLOT_W    = $clog2(ENT_CHARS);

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_W-1:0]  ROW_PIXELS_RST = CFG_W'(8);
  localparam logic [CHAR_W-1:0] CH_END_MARK    = CHAR_W'(5);
  localparam logic [CHAR_W-1:0] CH_NEWLINE     = CHAR_W'(10);

  // One queue entry: the characters that a pixel byte produced.
  typedef struct packed {
    logic [ENT_CHARS-1:0][CHAR_W-1:0] chars;
    logic [SLOT_W-1:0]                last_slot;
  } bm6_entry_t;

  // Queue status seen by its producer and consumer.
  typedef struct packed {
    logic not_empty;
    logic not_full;
  } bm6_q_stat_t;

  // Graphics character: unit reversed (first pixel to bit 0) plus 64.
  function automatic logic [CHAR_W-1:0] unit_char(input logic [UNIT_W-1:0] unit);
    logic [UNIT_W-1:0] rev;
    for (int i = 0; i < UNIT_W; i++) begin
      rev[i] = unit[UNIT_W-1-i];
    end
    return {1'b1, rev};
  endfunction

endpackage

>>> src/bm6_front.sv
// Front part: holds the row width, takes pixel words and turns each into a list of characters.
module bm6_front
  import bm6_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_row_pixels,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BYTE_W-1:0]  in_pixel_byte,
  input  bm6_q_stat_t        q_stat,
  output logic               q_push,
  output bm6_entry_t         q_entry
);

  logic [CFG_W-1:0]   row_pixels_r;
  logic [CARRY_W-1:0] carry_bits_r, carry_bits_nxt;
  logic [CCNT_W-1:0]  carry_cnt_r, carry_cnt_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;

  logic [EXT_W-1:0]   width_w;
  logic [EXT_W-1:0]   pos_ext;
  logic [EXT_W-1:0]   diff_w;
  logic               past_end;
  logic               row_end;
  logic [NCNT_W-1:0]  valid_w;
  logic [NCNT_W-1:0]  n_w;
  logic [NCNT_W-1:0]  rem_w;
  logic [ACC_W-1:0]   acc_w;
  logic [ACC_W-1:0]   rem_acc;
  logic [UNIT_W-1:0]  unit_a;
  logic [UNIT_W-1:0]  unit_b;
  logic [UNIT_W-1:0]  unit_p;
  logic               accept;

  assign in_ready = q_stat.not_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  // Effective width: zero acts as one, anything above the limit as the limit.
  always_comb begin
    width_w = EXT_W'(row_pixels_r);
    if (row_pixels_r == '0) begin
      width_w = EXT_W'(1);
    end else if (EXT_W'(row_pixels_r) > EXT_W'(MAX_ROW_PIXELS)) begin
      width_w = EXT_W'(MAX_ROW_PIXELS);
    end
  end

  assign pos_ext  = EXT_W'(pos_r);
  assign past_end = (pos_ext >= width_w);
  assign diff_w   = width_w - pos_ext;
  assign row_end  = past_end || (diff_w <= EXT_W'(BYTE_W));

  always_comb begin
    if (past_end) begin
      valid_w = '0;
    end else if (diff_w >= EXT_W'(BYTE_W)) begin
      valid_w = NCNT_W'(BYTE_W);
    end else begin
      valid_w = diff_w[NCNT_W-1:0];
    end
  end

  assign acc_w = (ACC_W'(carry_bits_r) << valid_w)
               | (ACC_W'(in_pixel_byte) >> (NCNT_W'(BYTE_W) - valid_w));
  assign n_w   = NCNT_W'(carry_cnt_r) + valid_w;

  always_comb begin
    unit_a = acc_w[ACC_W-1:UNIT_W];
    unit_b = acc_w[UNIT_W-1:0];
    if (n_w >= NCNT_W'(2 * UNIT_W)) begin
      rem_w = '0;
    end else if (n_w >= NCNT_W'(UNIT_W)) begin
      rem_w  = n_w - NCNT_W'(UNIT_W);
      unit_a = UNIT_W'(acc_w >> rem_w);
    end else begin
      rem_w = n_w;
    end
    rem_acc = acc_w & ~({ACC_W{1'b1}} << rem_w);
    unit_p  = UNIT_W'(rem_acc << (NCNT_W'(UNIT_W) - rem_w));
  end

  // Build the character list in output order.
  always_comb begin
    logic [SLOT_W:0] k;
    k = '0;
    q_entry = '0;
    if (n_w >= NCNT_W'(UNIT_W)) begin
      q_entry.chars[k[SLOT_W-1:0]] = unit_char(unit_a);
      k = k + 1'b1;
    end
    if (n_w >= NCNT_W'(2 * UNIT_W)) begin
      q_entry.chars[k[SLOT_W-1:0]] = unit_char(unit_b);
      k = k + 1'b1;
    end
    if (row_end) begin
      if (rem_w != '0) begin
        q_entry.chars[k[SLOT_W-1:0]] = unit_char(unit_p);
        k = k + 1'b1;
      end
      q_entry.chars[k[SLOT_W-1:0]] = CH_END_MARK;
      k = k + 1'b1;
      q_entry.chars[k[SLOT_W-1:0]] = CH_NEWLINE;
      k = k + 1'b1;
    end
    q_entry.last_slot = SLOT_W'(k - 1'b1);
  end

  always_comb begin
    if (row_end) begin
      carry_bits_nxt = '0;
      carry_cnt_nxt  = '0;
      pos_nxt        = '0;
    end else begin
      carry_bits_nxt = rem_acc[CARRY_W-1:0];
      carry_cnt_nxt  = rem_w[CCNT_W-1:0];
      pos_nxt        = pos_r + POS_W'(BYTE_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pixels_r <= ROW_PIXELS_RST;
      carry_bits_r <= '0;
      carry_cnt_r  <= '0;
      pos_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        row_pixels_r <= cfg_row_pixels;
      end
      if (accept) begin
        carry_bits_r <= carry_bits_nxt;
        carry_cnt_r  <= carry_cnt_nxt;
        pos_r        <= pos_nxt;
      end
    end
  end

endmodule

>>> src/bm6_queue.sv
// Short queue of character lists between the front and the back.
module bm6_queue
  import bm6_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  bm6_entry_t  push_entry,
  input  logic        pop,
  output bm6_entry_t  head,
  output bm6_q_stat_t stat
);

  bm6_entry_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0]   cnt_r;
  logic              do_push, do_pop;

  assign stat.not_empty = (cnt_r != '0);
  assign stat.not_full  = (cnt_r != Q_CW'(Q_DEPTH));
  assign do_push        = push && stat.not_full;
  assign do_pop         = pop && stat.not_empty;
  assign head           = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> src/bm6_back.sv
// Back part: walks the head character list and drives the registered output channel.
module bm6_back
  import bm6_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  bm6_entry_t        head,
  input  bm6_q_stat_t       q_stat,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  logic [SLOT_W-1:0] slot_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;
  logic              load;
  logic              at_last;

  assign load      = q_stat.not_empty && (!out_valid_r || out_ready);
  assign at_last   = (slot_r == head.last_slot);
  assign q_pop     = load && at_last;
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r <= head.chars[slot_r];
      out_last_r <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      slot_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        slot_r      <= at_last ? '0 : slot_r + 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> src/bitmap_row_to_six_bit_printer_chars.sv
// Top level: bitmap row bytes in, six-bit printer characters out.
// A word's first character is written into the queue entry and then into the output register.
// Throughput: one character per cycle while the output is not stalled, set by the single-character
// output register; a mid-row word gives one or two characters, the word that ends a row up to four.
// Input words are taken every cycle while the two-entry queue has room.
// Synchronous active-low reset: row width returns to 8, the row restarts, queue and output empty.
module bitmap_row_to_six_bit_printer_chars
  import bm6_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_row_pixels,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_pixel_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  // The front computes, for each accepted word, every character that word causes: the
  // full six-pixel units, and at the end of the row the zero-padded partial unit, the end
  // mark and the newline. The whole list goes into the queue as one entry, so the front
  // never waits on the output side unless the queue is full.
  bm6_entry_t  push_entry;
  bm6_entry_t  head;
  bm6_q_stat_t q_stat;
  logic        q_push;
  logic        q_pop;

  bm6_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_row_pixels (cfg_row_pixels),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_byte  (in_pixel_byte),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_entry        (push_entry)
  );

  // The queue decouples the two sides: a stalled output does not stop the front until
  // both entries are occupied.
  bm6_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .stat       (q_stat)
  );

  // The back hands out the head entry one character at a time through the output
  // register, marking the final character of each entry, and frees the entry with it.
  bm6_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

>>> src/bm6_checker.sv
// Port-level checker for the printer character block, with its bind.
module bm6_checker
  import bm6_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_char,
  input logic              out_last
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("output word changed while stalled");

  // The end mark is followed at once by the newline that closes the word's list.
  a_end_then_nl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_char == CH_END_MARK
    |=> out_valid && out_char == CH_NEWLINE && out_last)
    else $error("end mark not followed by newline");

  // A newline always closes the list of its input word.
  a_nl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char == CH_NEWLINE |-> out_last)
    else $error("newline without last");

  // Only graphics characters and the end mark appear before the last character.
  a_mid_chars: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_char[CHAR_W-1] || out_char == CH_END_MARK)
    else $error("unexpected character before last");

endmodule

bind bitmap_row_to_six_bit_printer_chars bm6_checker u_bm6_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_char  (out_char),
  .out_last  (out_last)
);
